/* hdl/c85x_pkg.sv */
package c85x_pkg;

	typedef enum logic [4:0] {
		OP_MOV  = 5'd0,
		OP_MVI  = 5'd1,
		OP_LDA  = 5'd2,
		OP_STA  = 5'd3,
		OP_LXI  = 5'd4,
		OP_LHLD = 5'd5,
		OP_SHLD = 5'd6,
		OP_STAX = 5'd7,
		OP_XCHG = 5'd8,
		OP_ADD  = 5'd9,
		OP_ADI  = 5'd10,
		OP_INR  = 5'd11,
		OP_INX  = 5'd12,
		OP_DAD  = 5'd13,
		OP_SUB  = 5'd14,
		OP_SUI  = 5'd15,
		OP_DCR  = 5'd16,
		OP_DCX  = 5'd17,
		OP_CMA  = 5'd18,
		OP_CMP  = 5'd19
	} op_t;

	localparam logic [2:0] REG_A = 3'd0;
	localparam logic [2:0] REG_H = 3'd5;
	localparam logic [2:0] REG_L = 3'd6;
	localparam logic [2:0] REG_M = 3'd7;

	localparam logic [1:0] PAIR_BC = 2'd0;
	localparam logic [1:0] PAIR_DE = 2'd1;
	localparam logic [1:0] PAIR_HL = 2'd2;

	localparam int F_CY = 0;
	localparam int F_P  = 1;
	localparam int F_AC = 2;
	localparam int F_Z  = 3;
	localparam int F_S  = 4;

	typedef struct packed {
		logic [4:0]  mode;
		logic [2:0]  dst_reg;
		logic [2:0]  src_reg;
		logic [1:0]  pair_sel;
		logic [7:0]  imm_byte;
		logic [15:0] imm_word;
	} req_t;

	typedef struct packed {
		logic [7:0] reg_a;
		logic [7:0] reg_b;
		logic [7:0] reg_c;
		logic [7:0] reg_d;
		logic [7:0] reg_e;
		logic [7:0] reg_h;
		logic [7:0] reg_l;
		logic [4:0] flag_bits;
	} rsp_t;

	// decoded request passed from front to back
	typedef struct packed {
		req_t       req;
		logic       mem_use;   // memory touched at HL via reg index 7
		logic       two_byte;  // lhld / shld
		logic       pair_ok;
	} dec_t;

endpackage

/* hdl/c85x_if.sv */
interface c85x_req_if import c85x_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface c85x_rsp_if import c85x_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/c85x_front.sv */
module c85x_front import c85x_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	c85x_req_if.sink    req,
	output logic        q_valid,
	output dec_t        q_data,
	input  logic        q_pop
);

	localparam int DEPTH = 2;

	dec_t        fifo_q [DEPTH];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;
	dec_t        dec;
	logic        push;

	always_comb begin
		dec.req = req.data;
		dec.pair_ok = req.data.pair_sel != 2'd3;
		dec.two_byte = req.data.mode == OP_LHLD || req.data.mode == OP_SHLD;
		case (req.data.mode)
			OP_MOV:  dec.mem_use = req.data.dst_reg == REG_M || req.data.src_reg == REG_M;
			OP_MVI, OP_ADD, OP_INR, OP_SUB, OP_DCR, OP_CMP:
				dec.mem_use = req.data.dst_reg == REG_M;
			default: dec.mem_use = 1'b0;
		endcase
	end

	assign req.ready = cnt_q != 2'(DEPTH);
	assign push = req.valid && req.ready;
	assign q_valid = cnt_q != 2'd0;
	assign q_data = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

/* hdl/c85x_back.sv */
module c85x_back import c85x_pkg::*; #(
	parameter int MEM_ADDR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  dec_t        q_data,
	output logic        q_pop,
	c85x_rsp_if.source  rsp
);

	localparam int MEM_SIZE = 1 << MEM_ADDR_BITS;

	typedef enum logic [3:0] {
		ST_CLR  = 4'b0001,
		ST_RUN  = 4'b0010,
		ST_RD2  = 4'b0100,
		ST_WR2  = 4'b1000
	} st_t;

	st_t state_q;
	logic [7:0] mem [MEM_SIZE];
	logic [MEM_ADDR_BITS-1:0] clr_q;
	logic [7:0] rf_q [7];
	logic [4:0] fl_q;
	logic [7:0] rdata_q;
	logic       rd_pend_q;      // rdata_q valid for head op (phase 2)
	logic [MEM_ADDR_BITS-1:0] addr2_q;
	logic       out_valid_q;
	rsp_t       out_q;

	// memory port signals
	logic                      m_we;
	logic [MEM_ADDR_BITS-1:0]  m_addr;
	logic [7:0]                m_wd;

	logic [MEM_ADDR_BITS-1:0] hl_a, w_a, w1_a;
	req_t r;
	logic out_free, exec, out_set;
	logic [7:0] rf_n [7];
	logic [4:0] fl_n;
	logic [7:0] opnd, res8;
	logic [8:0] sum9;
	logic [15:0] pr_v, pr_n;
	logic [16:0] dad17;
	logic [2:0] phi;
	logic need_rd;
	logic parity;

	assign r = q_data.req;
	assign hl_a = MEM_ADDR_BITS'({rf_q[5], rf_q[6]});
	assign w_a = MEM_ADDR_BITS'(r.imm_word);
	assign w1_a = MEM_ADDR_BITS'(r.imm_word + 16'd1);
	assign out_free = !out_valid_q || rsp.ready;
	assign phi = {r.pair_sel, 1'b1};
	assign pr_v = {rf_q[phi], rf_q[phi + 3'd1]};

	// reads needed before execute: memory operand or lda/lhld byte
	assign need_rd = q_data.mem_use && !(r.mode == OP_MVI) || r.mode == OP_LDA
		|| r.mode == OP_LHLD;

	always_comb begin
		rf_n = rf_q;
		fl_n = fl_q;
		opnd = 8'd0;
		res8 = 8'd0;
		sum9 = 9'd0;
		pr_n = 16'd0;
		dad17 = 17'd0;
		m_we = 1'b0;
		m_addr = hl_a;
		m_wd = rf_q[REG_A];
		exec = 1'b0;
		parity = 1'b0;
		if (state_q == ST_RUN && q_valid) begin
			// hold the read address while the result side stalls
			if (need_rd)
				m_addr = (r.mode == OP_LDA || r.mode == OP_LHLD) ? w_a : hl_a;
			if (out_free && (!need_rd || rd_pend_q)) begin
				exec = 1'b1;
				opnd = (r.dst_reg == REG_M) ? rdata_q : rf_q[r.dst_reg];
				unique case (r.mode)
					OP_MOV: begin
						res8 = (r.src_reg == REG_M) ? rdata_q : rf_q[r.src_reg];
						if (r.dst_reg == REG_M) begin
							m_we = 1'b1; m_wd = res8;
						end else rf_n[r.dst_reg] = res8;
					end
					OP_MVI: begin
						if (r.dst_reg == REG_M) begin
							m_we = 1'b1; m_wd = r.imm_byte;
						end else rf_n[r.dst_reg] = r.imm_byte;
					end
					OP_LDA: rf_n[REG_A] = rdata_q;
					OP_STA: begin m_we = 1'b1; m_addr = w_a; end
					OP_LXI: if (q_data.pair_ok) begin
						rf_n[phi] = r.imm_word[15:8]; rf_n[phi + 3'd1] = r.imm_word[7:0];
					end
					OP_LHLD: begin
						rf_n[REG_L] = rdata_q;
						m_addr = w1_a;  // second byte lands in rdata_q for ST_RD2
					end
					OP_SHLD: begin
						m_we = 1'b1; m_addr = w_a; m_wd = rf_q[REG_L];
					end
					OP_STAX: if (q_data.pair_ok) begin
						m_we = 1'b1; m_addr = MEM_ADDR_BITS'(pr_v);
					end
					OP_XCHG: begin
						rf_n[3] = rf_q[5]; rf_n[5] = rf_q[3];
						rf_n[4] = rf_q[6]; rf_n[6] = rf_q[4];
					end
					OP_ADD, OP_ADI: begin
						if (r.mode == OP_ADI) opnd = r.imm_byte;
						sum9 = {1'b0, rf_q[REG_A]} + {1'b0, opnd};
						res8 = sum9[7:0];
						fl_n[F_AC] = ({1'b0, rf_q[REG_A][3:0]} + {1'b0, opnd[3:0]}) > 5'd15;
						fl_n[F_CY] = sum9[8];
						rf_n[REG_A] = res8;
					end
					OP_SUB, OP_SUI, OP_CMP: begin
						if (r.mode == OP_SUI) opnd = r.imm_byte;
						res8 = rf_q[REG_A] - opnd;
						fl_n[F_AC] = rf_q[REG_A] < opnd;
						fl_n[F_CY] = rf_q[REG_A] < opnd;
						if (r.mode != OP_CMP) rf_n[REG_A] = res8;
					end
					OP_INR, OP_DCR: begin
						if (r.mode == OP_INR) begin
							res8 = opnd + 8'd1;
							fl_n[F_AC] = opnd[3:0] == 4'hF;
						end else begin
							res8 = opnd - 8'd1;
							if (opnd == 8'd0) fl_n[F_AC] = 1'b0;
						end
						if (r.dst_reg == REG_M) begin
							m_we = 1'b1; m_wd = res8;
						end else rf_n[r.dst_reg] = res8;
					end
					OP_INX, OP_DCX: if (q_data.pair_ok) begin
						pr_n = (r.mode == OP_INX) ? pr_v + 16'd1 : pr_v - 16'd1;
						rf_n[phi] = pr_n[15:8]; rf_n[phi + 3'd1] = pr_n[7:0];
					end
					OP_DAD: if (q_data.pair_ok) begin
						dad17 = {1'b0, rf_q[5], rf_q[6]} + {1'b0, pr_v};
						fl_n[F_CY] = dad17[16];
						rf_n[5] = dad17[15:8]; rf_n[6] = dad17[7:0];
					end
					OP_CMA: rf_n[REG_A] = ~rf_q[REG_A];
					default: ;
				endcase
				case (r.mode)
					OP_ADD, OP_ADI, OP_SUB, OP_SUI, OP_CMP, OP_INR, OP_DCR: begin
						parity = ~^res8;
						fl_n[F_S] = res8[7];
						fl_n[F_Z] = res8 == 8'd0;
						fl_n[F_P] = parity;
					end
					default: ;
				endcase
			end
		end else if (state_q == ST_RD2) begin
			m_addr = addr2_q;
		end else if (state_q == ST_WR2) begin
			m_we = 1'b1; m_addr = addr2_q; m_wd = rf_q[REG_H];
		end else if (state_q == ST_CLR) begin
			m_we = 1'b1; m_addr = clr_q; m_wd = 8'd0;
		end
	end

	assign q_pop = exec;
	assign out_set = (exec && r.mode != OP_LHLD && r.mode != OP_SHLD)
		|| state_q == ST_RD2 || state_q == ST_WR2;

	always_ff @(posedge clk) begin
		if (m_we) mem[m_addr] <= m_wd;
		rdata_q <= mem[m_addr];
	end

	always_ff @(posedge clk) begin
		if (exec) addr2_q <= w1_a;
		if (exec) out_q <= {rf_n[0], rf_n[1], rf_n[2], rf_n[3], rf_n[4],
			(r.mode == OP_LHLD) ? rf_q[REG_H] : rf_n[5], rf_n[6], fl_n};
		else if (state_q == ST_RD2) out_q.reg_h <= rdata_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			rd_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
			fl_q <= 5'd0;
			for (int i = 0; i < 7; i++) rf_q[i] <= 8'd0;
		end else begin
			if (out_set) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MEM_ADDR_BITS'(MEM_SIZE - 1)) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (exec) begin
						rd_pend_q <= 1'b0;
						rf_q <= rf_n;
						fl_q <= fl_n;
						if (r.mode == OP_LHLD) state_q <= ST_RD2;
						else if (r.mode == OP_SHLD) state_q <= ST_WR2;
					end else if (q_valid && need_rd) begin
						rd_pend_q <= 1'b1;
					end
				end
				ST_RD2: begin
					rf_q[REG_H] <= rdata_q;
					state_q <= ST_RUN;
				end
				ST_WR2: begin
					state_q <= ST_RUN;
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data = out_q;

endmodule

/* hdl/cpu8_register_alu_executor.sv */
// Path: input FIFO, then execute into the response register; a memory operand read
// precedes execute, SHLD writes H after it, LHLD runs read, execute, second read.
// Throughput: one request per cycle for register ops while rsp is ready; a memory
// operand read, SHLD or LHLD holds the next one; the single memory port sets this.
// Reset: arst_n clears registers and flags at once, then the memory is swept to zero,
// one byte per cycle over all 2**MEM_ADDR_BITS bytes, before requests are executed.
module cpu8_register_alu_executor import c85x_pkg::*; #(
	parameter int MEM_ADDR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	c85x_req_if.sink    req,
	c85x_rsp_if.source  rsp
);

	logic q_valid, q_pop;
	dec_t q_data;

	c85x_front u_front (
		.clk, .arst_n, .req,
		.q_valid, .q_data, .q_pop
	);

	c85x_back #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_back (
		.clk, .arst_n,
		.q_valid, .q_data, .q_pop,
		.rsp
	);

endmodule
